// ===== design/ctd_pkg.sv =====
package ctd_pkg;

  typedef struct packed {
    logic [7:0] text_char;
    logic       is_last;
  } ctd_in_t;

  typedef struct packed {
    logic [31:0] argb;
    logic        ok;
  } ctd_out_t;

  localparam int unsigned TableSlots = 256;
  localparam int unsigned NameStore  = 32;
  localparam int unsigned BuiltIn    = 141;
  localparam logic [5:0]  PosMax     = 6'd63;
  localparam logic [31:0] OpaqueMask = 32'hFF00_0000;

  // built-in name text, first letter in the top byte, zero padded
  function automatic logic [NameStore*8-1:0] name_text(input logic [7:0] k);
    logic [NameStore*8-1:0] s;
    s = '0;
    unique case (k)
      8'd0: s[255 -: 72] = "aliceblue";
      8'd1: s[255 -: 96] = "antiquewhite";
      8'd2: s[255 -: 32] = "aqua";
      8'd3: s[255 -: 80] = "aquamarine";
      8'd4: s[255 -: 40] = "azure";
      8'd5: s[255 -: 40] = "beige";
      8'd6: s[255 -: 48] = "bisque";
      8'd7: s[255 -: 40] = "black";
      8'd8: s[255 -: 112] = "blanchedalmond";
      8'd9: s[255 -: 32] = "blue";
      8'd10: s[255 -: 80] = "blueviolet";
      8'd11: s[255 -: 40] = "brown";
      8'd12: s[255 -: 72] = "burlywood";
      8'd13: s[255 -: 72] = "cadetblue";
      8'd14: s[255 -: 80] = "chartreuse";
      8'd15: s[255 -: 72] = "chocolate";
      8'd16: s[255 -: 40] = "coral";
      8'd17: s[255 -: 112] = "cornflowerblue";
      8'd18: s[255 -: 64] = "cornsilk";
      8'd19: s[255 -: 56] = "crimson";
      8'd20: s[255 -: 32] = "cyan";
      8'd21: s[255 -: 64] = "darkblue";
      8'd22: s[255 -: 64] = "darkcyan";
      8'd23: s[255 -: 104] = "darkgoldenrod";
      8'd24: s[255 -: 64] = "darkgray";
      8'd25: s[255 -: 72] = "darkgreen";
      8'd26: s[255 -: 72] = "darkkhaki";
      8'd27: s[255 -: 88] = "darkmagenta";
      8'd28: s[255 -: 112] = "darkolivegreen";
      8'd29: s[255 -: 80] = "darkorange";
      8'd30: s[255 -: 80] = "darkorchid";
      8'd31: s[255 -: 56] = "darkred";
      8'd32: s[255 -: 80] = "darksalmon";
      8'd33: s[255 -: 96] = "darkseagreen";
      8'd34: s[255 -: 104] = "darkslateblue";
      8'd35: s[255 -: 104] = "darkslategray";
      8'd36: s[255 -: 104] = "darkturquoise";
      8'd37: s[255 -: 80] = "darkviolet";
      8'd38: s[255 -: 64] = "deeppink";
      8'd39: s[255 -: 88] = "deepskyblue";
      8'd40: s[255 -: 56] = "dimgray";
      8'd41: s[255 -: 80] = "dodgerblue";
      8'd42: s[255 -: 72] = "firebrick";
      8'd43: s[255 -: 88] = "floralwhite";
      8'd44: s[255 -: 88] = "forestgreen";
      8'd45: s[255 -: 56] = "fuchsia";
      8'd46: s[255 -: 72] = "gainsboro";
      8'd47: s[255 -: 80] = "ghostwhite";
      8'd48: s[255 -: 32] = "gold";
      8'd49: s[255 -: 72] = "goldenrod";
      8'd50: s[255 -: 32] = "gray";
      8'd51: s[255 -: 40] = "green";
      8'd52: s[255 -: 88] = "greenyellow";
      8'd53: s[255 -: 64] = "honeydew";
      8'd54: s[255 -: 56] = "hotpink";
      8'd55: s[255 -: 72] = "indianred";
      8'd56: s[255 -: 48] = "indigo";
      8'd57: s[255 -: 40] = "ivory";
      8'd58: s[255 -: 40] = "khaki";
      8'd59: s[255 -: 64] = "lavender";
      8'd60: s[255 -: 104] = "lavenderblush";
      8'd61: s[255 -: 72] = "lawngreen";
      8'd62: s[255 -: 96] = "lemonchiffon";
      8'd63: s[255 -: 72] = "lightblue";
      8'd64: s[255 -: 80] = "lightcoral";
      8'd65: s[255 -: 72] = "lightcyan";
      8'd66: s[255 -: 160] = "lightgoldenrodyellow";
      8'd67: s[255 -: 72] = "lightgray";
      8'd68: s[255 -: 80] = "lightgreen";
      8'd69: s[255 -: 72] = "lightpink";
      8'd70: s[255 -: 88] = "lightsalmon";
      8'd71: s[255 -: 104] = "lightseagreen";
      8'd72: s[255 -: 96] = "lightskyblue";
      8'd73: s[255 -: 112] = "lightslategray";
      8'd74: s[255 -: 112] = "lightsteelblue";
      8'd75: s[255 -: 88] = "lightyellow";
      8'd76: s[255 -: 32] = "lime";
      8'd77: s[255 -: 72] = "limegreen";
      8'd78: s[255 -: 40] = "linen";
      8'd79: s[255 -: 56] = "magenta";
      8'd80: s[255 -: 48] = "maroon";
      8'd81: s[255 -: 128] = "mediumaquamarine";
      8'd82: s[255 -: 80] = "mediumblue";
      8'd83: s[255 -: 96] = "mediumorchid";
      8'd84: s[255 -: 96] = "mediumpurple";
      8'd85: s[255 -: 112] = "mediumseagreen";
      8'd86: s[255 -: 120] = "mediumslateblue";
      8'd87: s[255 -: 136] = "mediumspringgreen";
      8'd88: s[255 -: 120] = "mediumturquoise";
      8'd89: s[255 -: 120] = "mediumvioletred";
      8'd90: s[255 -: 96] = "midnightblue";
      8'd91: s[255 -: 72] = "mintcream";
      8'd92: s[255 -: 72] = "mistyrose";
      8'd93: s[255 -: 64] = "moccasin";
      8'd94: s[255 -: 88] = "navajowhite";
      8'd95: s[255 -: 32] = "navy";
      8'd96: s[255 -: 56] = "oldlace";
      8'd97: s[255 -: 40] = "olive";
      8'd98: s[255 -: 72] = "olivedrab";
      8'd99: s[255 -: 48] = "orange";
      8'd100: s[255 -: 72] = "orangered";
      8'd101: s[255 -: 48] = "orchid";
      8'd102: s[255 -: 104] = "palegoldenrod";
      8'd103: s[255 -: 72] = "palegreen";
      8'd104: s[255 -: 104] = "paleturquoise";
      8'd105: s[255 -: 104] = "palevioletred";
      8'd106: s[255 -: 80] = "papayawhip";
      8'd107: s[255 -: 72] = "peachpuff";
      8'd108: s[255 -: 32] = "peru";
      8'd109: s[255 -: 32] = "pink";
      8'd110: s[255 -: 32] = "plum";
      8'd111: s[255 -: 80] = "powderblue";
      8'd112: s[255 -: 48] = "purple";
      8'd113: s[255 -: 24] = "red";
      8'd114: s[255 -: 72] = "rosybrown";
      8'd115: s[255 -: 72] = "royalblue";
      8'd116: s[255 -: 88] = "saddlebrown";
      8'd117: s[255 -: 48] = "salmon";
      8'd118: s[255 -: 80] = "sandybrown";
      8'd119: s[255 -: 64] = "seagreen";
      8'd120: s[255 -: 64] = "seashell";
      8'd121: s[255 -: 48] = "sienna";
      8'd122: s[255 -: 48] = "silver";
      8'd123: s[255 -: 56] = "skyblue";
      8'd124: s[255 -: 72] = "slateblue";
      8'd125: s[255 -: 72] = "slategray";
      8'd126: s[255 -: 32] = "snow";
      8'd127: s[255 -: 88] = "springgreen";
      8'd128: s[255 -: 72] = "steelblue";
      8'd129: s[255 -: 24] = "tan";
      8'd130: s[255 -: 32] = "teal";
      8'd131: s[255 -: 56] = "thistle";
      8'd132: s[255 -: 48] = "tomato";
      8'd133: s[255 -: 72] = "turquoise";
      8'd134: s[255 -: 48] = "violet";
      8'd135: s[255 -: 40] = "wheat";
      8'd136: s[255 -: 40] = "white";
      8'd137: s[255 -: 80] = "whitesmoke";
      8'd138: s[255 -: 48] = "yellow";
      8'd139: s[255 -: 88] = "yellowgreen";
      8'd140: s[255 -: 88] = "transparent";
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] name_color(input logic [7:0] k);
    logic [31:0] c;
    unique case (k)
      8'd0: c = 32'hFFF0F8FF; 8'd1: c = 32'hFFFAEBD7; 8'd2: c = 32'hFF00FFFF;
      8'd3: c = 32'hFF7FFFD4; 8'd4: c = 32'hFFF0FFFF; 8'd5: c = 32'hFFF5F5DC;
      8'd6: c = 32'hFFFFE4C4; 8'd7: c = 32'hFF000000; 8'd8: c = 32'hFFFFEBCD;
      8'd9: c = 32'hFF0000FF; 8'd10: c = 32'hFF8A2BE2; 8'd11: c = 32'hFFA52A2A;
      8'd12: c = 32'hFFDEB887; 8'd13: c = 32'hFF5F9EA0; 8'd14: c = 32'hFF7FFF00;
      8'd15: c = 32'hFFD2691E; 8'd16: c = 32'hFFFF7F50; 8'd17: c = 32'hFF6495ED;
      8'd18: c = 32'hFFFFF8DC; 8'd19: c = 32'hFFDC143C; 8'd20: c = 32'hFF00FFFF;
      8'd21: c = 32'hFF00008B; 8'd22: c = 32'hFF008B8B; 8'd23: c = 32'hFFB8860B;
      8'd24: c = 32'hFFA9A9A9; 8'd25: c = 32'hFF006400; 8'd26: c = 32'hFFBDB76B;
      8'd27: c = 32'hFF8B008B; 8'd28: c = 32'hFF556B2F; 8'd29: c = 32'hFFFF8C00;
      8'd30: c = 32'hFF9932CC; 8'd31: c = 32'hFF8B0000; 8'd32: c = 32'hFFE9967A;
      8'd33: c = 32'hFF8FBC8B; 8'd34: c = 32'hFF483D8B; 8'd35: c = 32'hFF2F4F4F;
      8'd36: c = 32'hFF00CED1; 8'd37: c = 32'hFF9400D3; 8'd38: c = 32'hFFFF1493;
      8'd39: c = 32'hFF00BFFF; 8'd40: c = 32'hFF696969; 8'd41: c = 32'hFF1E90FF;
      8'd42: c = 32'hFFB22222; 8'd43: c = 32'hFFFFFAF0; 8'd44: c = 32'hFF228B22;
      8'd45: c = 32'hFFFF00FF; 8'd46: c = 32'hFFDCDCDC; 8'd47: c = 32'hFFF8F8FF;
      8'd48: c = 32'hFFFFD700; 8'd49: c = 32'hFFDAA520; 8'd50: c = 32'hFF808080;
      8'd51: c = 32'hFF008000; 8'd52: c = 32'hFFADFF2F; 8'd53: c = 32'hFFF0FFF0;
      8'd54: c = 32'hFFFF69B4; 8'd55: c = 32'hFFCD5C5C; 8'd56: c = 32'hFF4B0082;
      8'd57: c = 32'hFFFFFFF0; 8'd58: c = 32'hFFF0E68C; 8'd59: c = 32'hFFE6E6FA;
      8'd60: c = 32'hFFFFF0F5; 8'd61: c = 32'hFF7CFC00; 8'd62: c = 32'hFFFFFACD;
      8'd63: c = 32'hFFADD8E6; 8'd64: c = 32'hFFF08080; 8'd65: c = 32'hFFE0FFFF;
      8'd66: c = 32'hFFFAFAD2; 8'd67: c = 32'hFFD3D3D3; 8'd68: c = 32'hFF90EE90;
      8'd69: c = 32'hFFFFB6C1; 8'd70: c = 32'hFFFFA07A; 8'd71: c = 32'hFF20B2AA;
      8'd72: c = 32'hFF87CEFA; 8'd73: c = 32'hFF778899; 8'd74: c = 32'hFFB0C4DE;
      8'd75: c = 32'hFFFFFFE0; 8'd76: c = 32'hFF00FF00; 8'd77: c = 32'hFF32CD32;
      8'd78: c = 32'hFFFAF0E6; 8'd79: c = 32'hFFFF00FF; 8'd80: c = 32'hFF800000;
      8'd81: c = 32'hFF66CDAA; 8'd82: c = 32'hFF0000CD; 8'd83: c = 32'hFFBA55D3;
      8'd84: c = 32'hFF9370DB; 8'd85: c = 32'hFF3CB371; 8'd86: c = 32'hFF7B68EE;
      8'd87: c = 32'hFF00FA9A; 8'd88: c = 32'hFF48D1CC; 8'd89: c = 32'hFFC71585;
      8'd90: c = 32'hFF191970; 8'd91: c = 32'hFFF5FFFA; 8'd92: c = 32'hFFFFE4E1;
      8'd93: c = 32'hFFFFE4B5; 8'd94: c = 32'hFFFFDEAD; 8'd95: c = 32'hFF000080;
      8'd96: c = 32'hFFFDF5E6; 8'd97: c = 32'hFF808000; 8'd98: c = 32'hFF6B8E23;
      8'd99: c = 32'hFFFFA500; 8'd100: c = 32'hFFFF4500; 8'd101: c = 32'hFFDA70D6;
      8'd102: c = 32'hFFEEE8AA; 8'd103: c = 32'hFF98FB98; 8'd104: c = 32'hFFAFEEEE;
      8'd105: c = 32'hFFDB7093; 8'd106: c = 32'hFFFFEFD5; 8'd107: c = 32'hFFFFDAB9;
      8'd108: c = 32'hFFCD853F; 8'd109: c = 32'hFFFFC0CB; 8'd110: c = 32'hFFDDA0DD;
      8'd111: c = 32'hFFB0E0E6; 8'd112: c = 32'hFF800080; 8'd113: c = 32'hFFFF0000;
      8'd114: c = 32'hFFBC8F8F; 8'd115: c = 32'hFF4169E1; 8'd116: c = 32'hFF8B4513;
      8'd117: c = 32'hFFFA8072; 8'd118: c = 32'hFFF4A460; 8'd119: c = 32'hFF2E8B57;
      8'd120: c = 32'hFFFFF5EE; 8'd121: c = 32'hFFA0522D; 8'd122: c = 32'hFFC0C0C0;
      8'd123: c = 32'hFF87CEEB; 8'd124: c = 32'hFF6A5ACD; 8'd125: c = 32'hFF708090;
      8'd126: c = 32'hFFFFFAFA; 8'd127: c = 32'hFF00FF7F; 8'd128: c = 32'hFF4682B4;
      8'd129: c = 32'hFFD2B48C; 8'd130: c = 32'hFF008080; 8'd131: c = 32'hFFD8BFD8;
      8'd132: c = 32'hFFFF6347; 8'd133: c = 32'hFF40E0D0; 8'd134: c = 32'hFFEE82EE;
      8'd135: c = 32'hFFF5DEB3; 8'd136: c = 32'hFFFFFFFF; 8'd137: c = 32'hFFF5F5F5;
      8'd138: c = 32'hFFFFFF00; 8'd139: c = 32'hFF9ACD32;
      default: c = 32'h0000_0000;
    endcase
    return c;
  endfunction

endpackage

// ===== design/ctd_name_match.sv =====
module ctd_name_match #(
  parameter int unsigned NUM_NAMES      = 141,
  parameter int unsigned MAX_NAME_CHARS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  clear_i,
  input  logic [5:0]            pos_i,
  input  logic [7:0]            lc_i,
  output logic                  hit_o,
  output logic [31:0]           color_o
);
  import ctd_pkg::*;

  logic [NUM_NAMES-1:0] alive_q, alive_d, done_w;

  // letter of entry k at position p, zero past the end or the length cap
  function automatic logic [7:0] letter(input int unsigned k, input logic [5:0] p);
    logic [NameStore*8-1:0] s;
    s = name_text(8'(k));
    if (k >= TableSlots || 32'(p) >= MAX_NAME_CHARS || 32'(p) >= NameStore)
      return 8'h00;
    return s[(NameStore*8-1) - 8*p[4:0] -: 8];
  endfunction

  always_comb begin
    for (int unsigned k = 0; k < NUM_NAMES; k++) begin
      alive_d[k] = alive_q[k] && (letter(k, pos_i) != 8'h00) && (letter(k, pos_i) == lc_i);
      done_w[k]  = alive_d[k] && (letter(k, pos_i + 6'd1) == 8'h00 || pos_i == PosMax);
    end
  end

  // lowest index wins
  always_comb begin
    hit_o   = 1'b0;
    color_o = '0;
    for (int k = NUM_NAMES - 1; k >= 0; k--) begin
      if (done_w[k]) begin
        hit_o   = 1'b1;
        color_o = name_color(8'(k));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= '1;
    end else if (step_i) begin
      alive_q <= clear_i ? '1 : alive_d;
    end
  end

endmodule

// ===== design/color_token_decoder.sv =====
// color token decoder: takes a color token one character per word, is_last on the final
// one, and returns one word per token with a 32-bit argb color and an ok flag. names are
// matched case-insensitively against the css keyword table plus transparent; failing that,
// exactly 6 or 8 hex digits give the color (6 digits force alpha to ff). one character is
// taken every cycle; the result word appears in the cycle after the last character, held in
// an output register, and input keeps flowing while that register is free or being taken.
module color_token_decoder #(
  parameter int unsigned NUM_NAMES      = 141,
  parameter int unsigned MAX_NAME_CHARS = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ctd_pkg::ctd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ctd_pkg::ctd_out_t out_data_o
);
  import ctd_pkg::*;

  logic [5:0]  pos_q;
  logic [31:0] hex_q;
  logic        hexok_q;
  logic        out_valid_q;
  ctd_out_t    out_q;

  logic        take;
  logic [7:0]  ch, lc;
  logic [3:0]  nib;
  logic        is_hex, hexok_d, name_hit;
  logic        out_valid_d;
  logic [31:0] hex_d, name_col;
  ctd_out_t    res;

  // stall only when the output register is full and not draining this cycle
  assign in_stall_o = out_valid_q && out_stall_i;
  assign take       = in_valid_i && !in_stall_o;
  assign ch         = in_data_i.text_char;
  assign lc         = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;

  always_comb begin
    is_hex = 1'b1;
    nib    = '0;
    if (ch >= "0" && ch <= "9")      nib = 4'(ch - "0");
    else if (ch >= "a" && ch <= "f") nib = 4'(ch - "W");
    else if (ch >= "A" && ch <= "F") nib = 4'(ch - "7");
    else                             is_hex = 1'b0;
  end

  // hex accumulator, digits shift in msd first
  assign hexok_d = hexok_q && (pos_q < 6'd8) && is_hex;
  assign hex_d   = hexok_d ? {hex_q[27:0], nib} : hex_q;

  ctd_name_match #(
    .NUM_NAMES     (NUM_NAMES),
    .MAX_NAME_CHARS(MAX_NAME_CHARS)
  ) u_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (take),
    .clear_i(in_data_i.is_last),
    .pos_i  (pos_q),
    .lc_i   (lc),
    .hit_o  (name_hit),
    .color_o(name_col)
  );

  // names first, then hex of length 6 or 8
  always_comb begin
    res = '0;
    if (name_hit) begin
      res.argb = name_col;
      res.ok   = 1'b1;
    end else if (hexok_d && (pos_q == 6'd5 || pos_q == 6'd7)) begin
      res.argb = (pos_q == 6'd5) ? (hex_d | OpaqueMask) : hex_d;
      res.ok   = 1'b1;
    end
  end

  // output word taken clears, a new last character refills in the same cycle
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (take && in_data_i.is_last)   out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      hex_q       <= '0;
      hexok_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        if (in_data_i.is_last) begin
          pos_q       <= '0;
          hex_q       <= '0;
          hexok_q     <= 1'b1;
        end else begin
          pos_q   <= (pos_q == PosMax) ? pos_q : pos_q + 6'd1;
          hex_q   <= hex_d;
          hexok_q <= hexok_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && in_data_i.is_last) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // a full output register that is stalled blocks input
  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o) else $error("input not stalled");

  // a last character always produces a word next cycle
  a_last_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && in_data_i.is_last) |=> out_valid_o) else $error("result word missing");

  // color is zero whenever ok is low
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.ok) |-> (out_data_o.argb == 32'h0)) else $error("bad color");

  // state back to reset after a token
  a_token_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && in_data_i.is_last) |=> (pos_q == 6'd0 && hexok_q)) else $error("no reset");
`endif

endmodule
